FILE: src/rcz_pkg.sv
// ----------------------------------------------------------------------------
// rcz_pkg: shared types for the rgb 3x3 convolution block
// item payloads, pixel and line-buffer entry layouts, register indexes
// ----------------------------------------------------------------------------
`default_nettype none

package rcz_pkg;

  // register index port width and widths of the geometry registers
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KERNEL_ROW0  = 3'd0,
    CFG_KERNEL_ROW1  = 3'd1,
    CFG_KERNEL_ROW2  = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_IMAGE_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // one line-buffer word: rows y-2 and y-1 at the same column
  typedef struct packed {
    pix_t older;
    pix_t newer;
  } lb_entry_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [9:0]  out_col;
    logic [11:0] out_row;
    logic        run_last;
    logic        frame_last;
  } pix_out_t;

endpackage

`default_nettype wire

FILE: src/rcz_cfg.sv
// ----------------------------------------------------------------------------
// rcz_cfg: configuration registers
// kernel rows as written, image geometry held already clamped
// ----------------------------------------------------------------------------
`default_nettype none

module rcz_cfg #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned COEF_BITS  = 8,
  localparam int unsigned XW        = $clog2(MAX_WIDTH),
  localparam int unsigned YW        = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned KernW     = 3 * COEF_BITS,
  localparam int unsigned CfgDataW  = (KernW > rcz_pkg::HeightRegW) ? KernW
                                                                   : rcz_pkg::HeightRegW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcz_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]                 cfg_wdata_i,
  output logic [2:0][KernW-1:0]               kernel_o,
  output logic [XW-1:0]                       wlast_o,
  output logic [YW-1:0]                       height_o
);
  import rcz_pkg::*;

  localparam int unsigned CmpWW = (XW + 1 > WidthRegW) ? XW + 1 : WidthRegW;
  localparam int unsigned CmpHW = (YW > HeightRegW) ? YW : HeightRegW;

  logic [2:0][KernW-1:0] kernel_q;
  logic [XW-1:0]         wlast_q;
  logic [YW-1:0]         height_q;

  // last column index of the clamped width
  function automatic logic [XW-1:0] width_to_last(input logic [WidthRegW-1:0] v);
    logic [XW-1:0] r;
    if (v < WidthRegW'(2)) begin
      r = XW'(1);
    end else if (CmpWW'(v) > CmpWW'(MAX_WIDTH)) begin
      r = XW'(MAX_WIDTH - 1);
    end else begin
      r = XW'(v - WidthRegW'(1));
    end
    return r;
  endfunction

  function automatic logic [YW-1:0] clamp_height(input logic [HeightRegW-1:0] v);
    logic [YW-1:0] r;
    if (v == '0) begin
      r = YW'(1);
    end else if (CmpHW'(v) > CmpHW'(MAX_HEIGHT)) begin
      r = YW'(MAX_HEIGHT);
    end else begin
      r = YW'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q[0] <= KernW'(24'h010101);
      kernel_q[1] <= '0;
      kernel_q[2] <= KernW'(24'hFFFFFF);
      wlast_q     <= width_to_last(WidthRegW'(512));
      height_q    <= clamp_height(HeightRegW'(512));
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_KERNEL_ROW0:  kernel_q[0] <= cfg_wdata_i[KernW-1:0];
        CFG_KERNEL_ROW1:  kernel_q[1] <= cfg_wdata_i[KernW-1:0];
        CFG_KERNEL_ROW2:  kernel_q[2] <= cfg_wdata_i[KernW-1:0];
        CFG_IMAGE_WIDTH:  wlast_q     <= width_to_last(cfg_wdata_i[WidthRegW-1:0]);
        CFG_IMAGE_HEIGHT: height_q    <= clamp_height(cfg_wdata_i[HeightRegW-1:0]);
        default: ;
      endcase
    end
  end

  assign kernel_o = kernel_q;
  assign wlast_o  = wlast_q;
  assign height_o = height_q;

endmodule

`default_nettype wire

FILE: src/rcz_linebuf.sv
// ----------------------------------------------------------------------------
// rcz_linebuf: line buffer memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rcz_linebuf #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned DW    = 48,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/rcz_sum.sv
// ----------------------------------------------------------------------------
// rcz_sum: 3x3 kernel sum per colour channel
// only the low 8 bits of each sum are kept, so products are taken mod 256
// ----------------------------------------------------------------------------
`default_nettype none

module rcz_sum #(
  parameter int unsigned COEF_BITS = 8,
  localparam int unsigned KernW    = 3 * COEF_BITS
) (
  input  rcz_pkg::pix_t [8:0]    win_i,
  input  logic [2:0][KernW-1:0]  kernel_i,
  output rcz_pkg::pix_t          sum_o
);
  import rcz_pkg::*;

  logic [8:0][7:0] coef8;
  logic [8:0][7:0] prod_r, prod_g, prod_b;
  logic [2:0][7:0] row_r, row_g, row_b;

  for (genvar gr = 0; gr < 3; gr++) begin : g_row
    for (genvar gc = 0; gc < 3; gc++) begin : g_col
      localparam int unsigned K = gr * 3 + gc;
      // signed coefficient folded to 8 bits
      assign coef8[K]  = 8'($signed(kernel_i[gr][COEF_BITS*gc +: COEF_BITS]));
      assign prod_r[K] = 8'(coef8[K] * win_i[K].red);
      assign prod_g[K] = 8'(coef8[K] * win_i[K].green);
      assign prod_b[K] = 8'(coef8[K] * win_i[K].blue);
    end
    assign row_r[gr] = prod_r[gr*3] + prod_r[gr*3+1] + prod_r[gr*3+2];
    assign row_g[gr] = prod_g[gr*3] + prod_g[gr*3+1] + prod_g[gr*3+2];
    assign row_b[gr] = prod_b[gr*3] + prod_b[gr*3+1] + prod_b[gr*3+2];
  end

  assign sum_o.red   = row_r[0] + row_r[1] + row_r[2];
  assign sum_o.green = row_g[0] + row_g[1] + row_g[2];
  assign sum_o.blue  = row_b[0] + row_b[1] + row_b[2];

endmodule

`default_nettype wire

FILE: src/rgb_conv3x3_zero_pad.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_zero_pad: streaming 3x3 rgb convolution with zero padding
// two line buffers, a 3x3 window and a per-channel kernel sum
// ----------------------------------------------------------------------------
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------
//   input   | in_valid_i / in_stall_o  | in_item_i  (kind, rgb pixel)
//   output  | out_valid_o / out_stall_i| out_item_o (rgb sum, col, row, flags)
//   config  | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// one item accepted per cycle while in_stall_o is low; an item that ends a row
// below the first gives two results and so holds the window stage until both
// are out; others give at most one, via line-buffer read, window and result register
// the single result register sets the rate: one result leaves per unstalled cycle
// reset clears counters, window and valid flags; no memory clearing pass
// stalls on the output back up through the pipeline to in_stall_o
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_conv3x3_zero_pad #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096,
  parameter int unsigned COEF_BITS  = 8,
  localparam int unsigned KernW     = 3 * COEF_BITS,
  localparam int unsigned CfgDataW  = (KernW > rcz_pkg::HeightRegW) ? KernW
                                                                   : rcz_pkg::HeightRegW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  rcz_pkg::pix_in_t            in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output rcz_pkg::pix_out_t           out_item_o,
  input  logic                        cfg_we_i,
  input  logic [rcz_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0]         cfg_wdata_i
);
  import rcz_pkg::*;

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT + 1);

  // configuration
  logic [2:0][KernW-1:0] kernel;
  logic [XW-1:0]         wlast;
  logic [YW-1:0]         height;

  rcz_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COEF_BITS  (COEF_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .kernel_o    (kernel),
    .wlast_o     (wlast),
    .height_o    (height)
  );

  // ---------------------------------------------------------------- handshake
  logic accept;
  logic s1_v_q, s1_v_d;
  logic s1_adv;
  logic s2_ready, s2_done;
  logic main_pend_q, main_pend_d, edge_pend_q, edge_pend_d;
  logic out_ready, emit;
  logic out_v_q, out_v_d;

  // ------------------------------------------------------------ input stage
  // position of the next input pixel
  logic [XW-1:0] col_q, col_d;
  logic [YW-1:0] row_q, row_d;
  logic          flush_row, row_end;
  pix_t          in_pix;

  // stage 1: item waiting for its line-buffer word
  logic [XW-1:0] s1_x_q;
  logic [YW-1:0] s1_y_q;
  pix_t          s1_pix_q;
  logic          s1_flush_q, s1_end_q, s1_y1_q, s1_y2_q, s1_x0_q;

  assign flush_row = (row_q >= height);
  assign row_end   = (col_q >= wlast);
  // flush rows and kind one both count as a zero pixel
  assign in_pix    = (in_item_i.kind || flush_row) ? '0
                   : pix_t'{red:   in_item_i.red_in,
                            green: in_item_i.green_in,
                            blue:  in_item_i.blue_in};

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_v_q && !s2_ready;
  assign s1_adv     = s1_v_q && s2_ready;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    s1_v_d = s1_v_q;
    if (s1_adv) begin
      s1_v_d = 1'b0;
    end
    if (accept) begin
      s1_v_d = 1'b1;
      if (row_end) begin
        col_d = '0;
        // the flush row wraps to the start of the next image
        row_d = flush_row ? '0 : row_q + YW'(1);
      end else begin
        col_d = col_q + XW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q     <= col_q;
      s1_y_q     <= row_q;
      s1_pix_q   <= in_pix;
      s1_flush_q <= flush_row;
      s1_end_q   <= row_end;
      s1_y1_q    <= (row_q != '0);
      s1_y2_q    <= (row_q >= YW'(2));
      s1_x0_q    <= (col_q == '0);
    end
  end

  // -------------------------------------------------------------- line buffer
  // read at accept, written back when the item moves into the window;
  // back-to-back items never touch the same column
  lb_entry_t lb_rdata, lb_wdata;

  rcz_linebuf #(
    .DEPTH (MAX_WIDTH),
    .DW    ($bits(lb_entry_t))
  ) u_linebuf (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_x_q),
    .wdata_i (lb_wdata),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (lb_rdata)
  );

  assign lb_wdata = lb_entry_t'{older: lb_rdata.newer, newer: s1_pix_q};

  // ------------------------------------------------------------------ window
  // index row*3+col, row 0 is the oldest line, col 0 the leftmost
  pix_t [8:0] win_q, win_d;
  pix_t [2:0] new_col;

  // rows above the image read as zero padding
  assign new_col[0] = s1_y2_q ? lb_rdata.older : '0;
  assign new_col[1] = s1_y1_q ? lb_rdata.newer : '0;
  assign new_col[2] = s1_pix_q;

  always_comb begin
    win_d = win_q;
    if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        // left padding at column zero
        win_d[r*3+0] = s1_x0_q ? '0 : win_q[r*3+1];
        win_d[r*3+1] = s1_x0_q ? '0 : win_q[r*3+2];
        win_d[r*3+2] = new_col[r];
      end
    end
  end

  // stage 2: results still owed for the item now in the window
  logic [XW-1:0] s2_x_q;
  logic [11:0]   s2_row_q;
  logic          s2_flush_q;

  always_comb begin
    main_pend_d = main_pend_q;
    edge_pend_d = edge_pend_q;
    if (emit) begin
      if (main_pend_q) begin
        main_pend_d = 1'b0;
      end else begin
        edge_pend_d = 1'b0;
      end
    end
    if (s1_adv) begin
      main_pend_d = s1_y1_q && !s1_x0_q;
      edge_pend_d = s1_y1_q && s1_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      main_pend_q <= 1'b0;
      edge_pend_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      main_pend_q <= main_pend_d;
      edge_pend_q <= edge_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_x_q     <= s1_x_q;
      s2_row_q   <= 12'(s1_y_q - YW'(1));
      s2_flush_q <= s1_flush_q;
    end
  end

  // ----------------------------------------------------------------- results
  pix_t [8:0] edge_win, sel_win;
  pix_t       sum;
  pix_out_t   res;
  pix_out_t   out_q;

  // right edge: window shifted left with a zero right column
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      edge_win[r*3+0] = win_q[r*3+1];
      edge_win[r*3+1] = win_q[r*3+2];
      edge_win[r*3+2] = '0;
    end
  end

  assign sel_win = main_pend_q ? win_q : edge_win;

  rcz_sum #(
    .COEF_BITS (COEF_BITS)
  ) u_sum (
    .win_i    (sel_win),
    .kernel_i (kernel),
    .sum_o    (sum)
  );

  always_comb begin
    res.red_out    = sum.red;
    res.green_out  = sum.green;
    res.blue_out   = sum.blue;
    res.out_row    = s2_row_q;
    if (main_pend_q) begin
      res.out_col    = 10'(s2_x_q - XW'(1));
      res.run_last   = !edge_pend_q;
      res.frame_last = 1'b0;
    end else begin
      res.out_col    = 10'(s2_x_q);
      res.run_last   = 1'b1;
      res.frame_last = s2_flush_q;
    end
  end

  assign out_ready = !out_v_q || !out_stall_i;
  assign emit      = (main_pend_q || edge_pend_q) && out_ready;
  assign s2_done   = emit && res.run_last;
  assign s2_ready  = !(main_pend_q || edge_pend_q) || s2_done;
  assign out_v_d   = out_ready ? emit : out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  // the frame ends on a right-edge result, which is always the item's last
  a_frame_last_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_last |-> out_item_o.run_last)
    else $error("frame_last without run_last");

  // line-buffer write-back never collides with the read of the next item
  a_lb_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && accept |-> s1_x_q != col_q)
    else $error("line buffer read and write at one column");

  // an interior result needs a left neighbour column
  a_main_not_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    main_pend_q |-> s2_x_q != '0)
    else $error("interior result owed at column zero");

  // the edge result follows the interior result of a row end at once
  a_edge_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.run_last |=> out_valid_o)
    else $error("second result of a row end not ready");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the rgb 3x3 zero-padded convolution
// streams small images, extreme kernels and odd geometries through the block,
// predicts every output pixel in a scoreboard and compares field by field
// ----------------------------------------------------------------------------

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcz_pkg::*;

  // cycles with no item moving on either side before the run is declared hung
  localparam int unsigned StuckLimit = 2000;
  // length of the deliberate output hold-off that backs the pipeline up
  localparam int unsigned HoldCycles = 80;
  // quiet cycles after the last expected pixel
  localparam int unsigned DrainCycles = 6;
  // items sent in all before the random images stop
  localparam int unsigned RandomItems = 1530;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the line buffers, window and registers; every
  // accepted input item is folded in and its output pixels are queued
  // --------------------------------------------------------------------------
  class conv_scoreboard;
    bit [23:0]      kern_row [3];
    bit [10:0]      width_reg;
    bit [12:0]      height_reg;
    bit [23:0]      older_line [1024];
    bit [23:0]      newer_line [1024];
    bit [8:0][23:0] win;
    int unsigned    next_col;
    int unsigned    next_row;
    pix_out_t       pending_pixels [$];
    int unsigned    n_mismatch;

    function new();
      kern_row[0] = 24'h010101;
      kern_row[1] = 24'h000000;
      kern_row[2] = 24'hFFFFFF;
      width_reg   = 11'd512;
      height_reg  = 13'd512;
      win         = '0;
      next_col    = 0;
      next_row    = 0;
      n_mismatch  = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, bit [23:0] value);
      case (idx)
        CFG_KERNEL_ROW0:  kern_row[0] = value;
        CFG_KERNEL_ROW1:  kern_row[1] = value;
        CFG_KERNEL_ROW2:  kern_row[2] = value;
        CFG_IMAGE_WIDTH:  width_reg = value[10:0];
        CFG_IMAGE_HEIGHT: height_reg = value[12:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    // signed 8-bit coefficients times unsigned channels, wrapped to 8 bits
    function pix_out_t kernel_sum(bit [8:0][23:0] px, int unsigned col,
                                  int unsigned row, bit flast);
      pix_out_t      res;
      int            acc;
      byte           coef;
      bit [2:0][7:0] sums;
      for (int ch = 0; ch < 3; ch++) begin
        acc = 0;
        for (int k = 0; k < 9; k++) begin
          coef = kern_row[k / 3][8 * (k % 3) +: 8];
          acc += int'(coef) * int'(px[k][16 - 8 * ch +: 8]);
        end
        sums[ch] = acc[7:0];
      end
      res            = '0;
      res.red_out    = sums[0];
      res.green_out  = sums[1];
      res.blue_out   = sums[2];
      res.out_col    = col[9:0];
      res.out_row    = row[11:0];
      res.frame_last = flast;
      return res;
    endfunction

    function void note_input(pix_in_t item);
      int unsigned    w;
      int unsigned    h;
      int unsigned    x;
      int unsigned    y;
      bit             flush_row;
      bit             row_end;
      bit [23:0]      pix;
      bit [23:0]      top;
      bit [23:0]      mid;
      bit [8:0][23:0] rim_win;
      pix_out_t       res [$];
      w = (width_reg < 2) ? 2 : (width_reg > 1024) ? 1024 : width_reg;
      h = (height_reg < 1) ? 1 : (height_reg > 4096) ? 4096 : height_reg;
      x = next_col;
      y = next_row;
      flush_row = (y >= h);
      row_end   = (x >= w - 1);
      pix = (item.kind || flush_row) ? 24'h0 : {item.red_in, item.green_in, item.blue_in};
      top = (y >= 2) ? older_line[x] : 24'h0;
      mid = (y >= 1) ? newer_line[x] : 24'h0;
      older_line[x] = newer_line[x];
      newer_line[x] = pix;
      for (int r = 0; r < 3; r++) begin
        win[r * 3 + 0] = (x == 0) ? 24'h0 : win[r * 3 + 1];
        win[r * 3 + 1] = (x == 0) ? 24'h0 : win[r * 3 + 2];
        win[r * 3 + 2] = (r == 0) ? top : (r == 1) ? mid : pix;
      end
      if (y >= 1 && x >= 1) res.push_back(kernel_sum(win, x - 1, y - 1, 1'b0));
      if (y >= 1 && row_end) begin
        for (int r = 0; r < 3; r++) begin
          rim_win[r * 3 + 0] = win[r * 3 + 1];
          rim_win[r * 3 + 1] = win[r * 3 + 2];
          rim_win[r * 3 + 2] = 24'h0;
        end
        res.push_back(kernel_sum(rim_win, x, y - 1, flush_row));
      end
      if (res.size() > 0) res[res.size() - 1].run_last = 1'b1;
      foreach (res[i]) pending_pixels.push_back(res[i]);
      if (row_end) begin
        next_col = 0;
        next_row = flush_row ? 0 : y + 1;
      end else begin
        next_col = x + 1;
      end
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      n_mismatch++;
    endtask

    task compare_field(string name, logic [11:0] got, logic [11:0] want, pix_out_t at);
      if (got !== want)
        report($sformatf("%s at col %0d row %0d: got %0h want %0h",
                         name, at.out_col, at.out_row, got, want));
    endtask

    task check_result(pix_out_t got);
      pix_out_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel col %0d row %0d", got.out_col, got.out_row));
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("red_out", 12'(got.red_out), 12'(want.red_out), want);
      compare_field("green_out", 12'(got.green_out), 12'(want.green_out), want);
      compare_field("blue_out", 12'(got.blue_out), 12'(want.blue_out), want);
      compare_field("out_col", 12'(got.out_col), 12'(want.out_col), want);
      compare_field("out_row", got.out_row, want.out_row, want);
      compare_field("run_last", 12'(got.run_last), 12'(want.run_last), want);
      compare_field("frame_last", 12'(got.frame_last), 12'(want.frame_last), want);
    endtask

    task finish_check();
      if (pending_pixels.size() != 0)
        report($sformatf("%0d pixels never arrived", pending_pixels.size()));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, block ports and bench state
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  pix_in_t              in_item_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  pix_out_t             out_item_o;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [23:0]          cfg_wdata_i;

  conv_scoreboard sb;
  bit             tx_calm;        // sender offers back to back when set
  bit             rx_calm;        // receiver never stalls when set
  bit             hold_off_req;   // asks the receiver for one long hold-off
  int unsigned    n_sent;
  int unsigned    stuck_cycles = 0;

  always #2 clk_i = ~clk_i;

  rgb_conv3x3_zero_pad dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // --------------------------------------------------------------------------
  // monitor: results are checked before the same edge's input is folded in,
  // the latency keeps the two apart anyway
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
      if (in_valid_i && !in_stall_o) sb.note_input(in_item_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // watchdog: nothing moving for too long means the block has hung
  initial begin : watchdog
    while (stuck_cycles < StuckLimit) @(posedge clk_i);
    $display("FAIL rgb_conv3x3_zero_pad");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request so the window
  // stage and line-buffer read back up into in_stall_o
  initial begin : receiver
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall_i <= !rx_calm && ($urandom_range(99) < 38);
    end
  end

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------

  // random gaps before the item, then hold it until the block takes it
  task automatic drive_item(input pix_in_t item);
    while (!tx_calm && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  // wait until every predicted pixel is out, then let the pipe run dry;
  // the first edge lets the monitor see the last accepted item
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // one register write; the enable is lowered again before the task returns, so
  // back-to-back writes never raise and lower the enable in the same step
  task automatic write_reg(input cfg_idx_e idx, input bit [23:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic set_size(input bit [23:0] width_raw, input bit [23:0] height_raw);
    write_reg(CFG_IMAGE_WIDTH, width_raw);
    write_reg(CFG_IMAGE_HEIGHT, height_raw);
  endtask

  // real rows carry the odd kind-one pixel; flush rows get any kind at all
  task automatic send_rows(input int unsigned width, input int unsigned rows,
                           input bit flush);
    pix_in_t p;
    for (int i = 0; i < width * rows; i++) begin
      p.kind     = flush ? 1'($urandom_range(1)) : ($urandom_range(99) < 8);
      p.red_in   = 8'($urandom_range(255));
      p.green_in = 8'($urandom_range(255));
      p.blue_in  = 8'($urandom_range(255));
      drive_item(p);
    end
  endtask

  function automatic int unsigned clamp_dim(int unsigned raw, int unsigned lo,
                                            int unsigned hi);
    return (raw < lo) ? lo : (raw > hi) ? hi : raw;
  endfunction

  // random coefficients half the time, otherwise an all-zero, all-minus-one,
  // all-max or all-min row
  function automatic bit [23:0] pick_kernel();
    case ($urandom_range(7))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'h7F7F7F;
      3:       return 24'h808080;
      default: return 24'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    cfg_idx_e    kern_regs [3];
    int unsigned img;
    int unsigned w_raw;
    int unsigned h_raw;
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned rows_done;
    int unsigned h_new;
    sb = new();
    kern_regs = '{CFG_KERNEL_ROW0, CFG_KERNEL_ROW1, CFG_KERNEL_ROW2};
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    hold_off_req = 1'b0;
    n_sent       = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_KERNEL_ROW0;
    cfg_wdata_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // width below range acts as two, height zero as one; only the middle
    // kernel row sees data, with coefficients -1, -128 and 127
    write_reg(CFG_KERNEL_ROW0, 24'h000000);
    write_reg(CFG_KERNEL_ROW1, 24'h7F80FF);
    write_reg(CFG_KERNEL_ROW2, 24'hFFFFFF);
    set_size(24'd1, 24'd0);
    drive_item('{1'b0, 8'hFF, 8'hFF, 8'hFF});
    drive_item('{1'b0, 8'h00, 8'h00, 8'h00});
    // flush row: contents dropped whatever the kind
    drive_item('{1'b0, 8'h12, 8'h34, 8'h56});
    drive_item('{1'b1, 8'hFF, 8'hFF, 8'hFF});
    settle();

    // 3x3 image with extreme coefficients and a kind-one pixel in the centre
    write_reg(CFG_KERNEL_ROW0, 24'h808080);
    write_reg(CFG_KERNEL_ROW1, 24'h7F7F7F);
    write_reg(CFG_KERNEL_ROW2, 24'h010101);
    set_size(24'd3, 24'd3);
    drive_item('{1'b0, 8'hFF, 8'hFF, 8'hFF});
    drive_item('{1'b0, 8'h00, 8'h00, 8'h00});
    drive_item('{1'b0, 8'hFF, 8'h00, 8'h80});
    drive_item('{1'b0, 8'h00, 8'hFF, 8'h7F});
    drive_item('{1'b1, 8'hFF, 8'hFF, 8'hFF});
    drive_item('{1'b0, 8'hFF, 8'hFF, 8'hFF});
    drive_item('{1'b0, 8'h80, 8'h01, 8'hFE});
    drive_item('{1'b0, 8'hFF, 8'hFF, 8'hFF});
    drive_item('{1'b0, 8'h00, 8'h00, 8'h00});
    drive_item('{1'b1, 8'hAA, 8'h55, 8'hAA});
    drive_item('{1'b0, 8'hFF, 8'hFF, 8'hFF});
    drive_item('{1'b1, 8'h00, 8'h00, 8'h00});
    settle();

    // sizes changed mid-image: the width shrinks under a column past the new
    // last one, which ends the row; then the height drops so the next row
    // is the flush row
    set_size(24'd4, 24'd8191);
    send_rows(4, 1, 1'b0);
    send_rows(3, 1, 1'b0);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 24'd2);
    send_rows(1, 1, 1'b0);
    settle();
    write_reg(CFG_IMAGE_HEIGHT, 24'd2);
    send_rows(2, 1, 1'b1);
    settle();

    // random images, mostly well formed, some cut short by a height change
    img = 0;
    while (n_sent < RandomItems) begin
      img++;
      foreach (kern_regs[r])
        if ($urandom_range(1)) write_reg(kern_regs[r], pick_kernel());
      case ($urandom_range(19))
        0:       w_raw = 0;
        1:       w_raw = 1;
        default: w_raw = $urandom_range(14, 2);
      endcase
      h_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
      set_size(24'(w_raw), 24'(h_raw));
      w_eff = clamp_dim(w_raw, 2, 1024);
      h_eff = clamp_dim(h_raw, 1, 4096);
      // a long output hold-off now and then while items keep coming
      if (img % 17 == 4) hold_off_req = 1'b1;
      if (h_eff >= 2 && $urandom_range(99) < 15) begin
        rows_done = $urandom_range(h_eff - 1, 1);
        send_rows(w_eff, rows_done, 1'b0);
        settle();
        h_raw = $urandom_range(6, 1);
        write_reg(CFG_IMAGE_HEIGHT, 24'(h_raw));
        h_new = clamp_dim(h_raw, 1, 4096);
        if (rows_done < h_new) send_rows(w_eff, h_new - rows_done, 1'b0);
      end else begin
        send_rows(w_eff, h_eff, 1'b0);
      end
      send_rows(w_eff, 1, 1'b1);
      settle();
    end

    // wider image with no idling on either side for the whole image
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    foreach (kern_regs[r]) write_reg(kern_regs[r], pick_kernel());
    set_size(24'd96, 24'd2);
    send_rows(96, 2, 1'b0);
    send_rows(96, 1, 1'b1);
    settle();
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // one more short image under random idling after the calm stretch
    set_size(24'd5, 24'd2);
    send_rows(5, 2, 1'b0);
    send_rows(5, 1, 1'b1);
    settle();

    sb.finish_check();
    if (sb.n_mismatch == 0) begin
      $display("PASS rgb_conv3x3_zero_pad");
    end else begin
      $display("FAIL rgb_conv3x3_zero_pad");
    end
    $finish;
  end

endmodule
